// ===== rtl/b64w_pkg.sv =====
// ============================================================================
// b64w_pkg
// Shared types and constants for the line-wrapping base64 encoder.
// ============================================================================
`default_nettype none

package b64w_pkg;

    localparam int unsigned MAX_RESULTS = 4;

    localparam logic [7:0] CHAR_CR        = 8'd13;
    localparam logic [7:0] CHAR_PAD       = 8'd61;
    localparam logic [7:0] LINE_LEN_RESET = 8'd75;
    localparam logic [7:0] LINE_LEN_MIN   = 8'd4;

    localparam logic FUNC_DATA  = 1'b0;
    localparam logic FUNC_FLUSH = 1'b1;

    typedef struct packed {
        logic       func;
        logic [7:0] data_byte;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_char;
        logic       run_last;
    } t_out_item;

    // Characters produced by one item, first character in entry 0.
    typedef struct packed {
        logic [MAX_RESULTS-1:0][7:0] chars;
        logic [2:0]                  count;
    } t_char_list;

    // Status of the result queue, seen by the intake control.
    typedef struct packed {
        logic busy;
        logic last_go;
    } t_queue_status;

    // Standard base64 alphabet.
    function automatic logic [7:0] sextet_char(input logic [5:0] idx);
        logic [7:0] c;
        if (idx < 6'd26) begin
            c = 8'd65 + {2'b00, idx};
        end else if (idx < 6'd52) begin
            c = 8'd97 + {2'b00, idx} - 8'd26;
        end else if (idx < 6'd62) begin
            c = 8'd48 + {2'b00, idx} - 8'd52;
        end else if (idx == 6'd62) begin
            c = 8'd43;
        end else begin
            c = 8'd47;
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/b64w_core.sv =====
// ============================================================================
// b64w_core
// Encoding state and the single-pass logic that turns one item into its list
// of output characters.
// ============================================================================
`default_nettype none

module b64w_core (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_fire,
    input  wire b64w_pkg::t_in_item    i_item,
    input  wire logic [7:0]            i_line_length,
    output b64w_pkg::t_char_list       o_list
);

    logic [3:0] r_bits;
    logic [2:0] r_cnt;
    logic [7:0] r_col;
    logic       r_pending;

    logic [3:0] n_bits;
    logic [2:0] n_cnt;
    logic [7:0] n_col;
    logic       n_pending;

    always_comb begin
        logic [3:0]       v_bits;
        logic [2:0]       v_cnt;
        logic [11:0]      v_acc;
        logic [7:0][7:0]  v_buf;
        logic [3:0]       v_n;
        logic [7:0]       v_col;
        logic [7:0]       v_lim;
        logic [2:0][7:0]  v_seq;
        logic [1:0]       v_m;

        v_bits = r_bits;
        v_cnt  = r_cnt;
        if (!(r_cnt == 3'd2 || r_cnt == 3'd4)) begin
            v_bits = 4'd0;
            v_cnt  = 3'd0;
        end
        v_acc  = {v_bits, i_item.data_byte};
        v_buf  = '0;
        v_n    = 4'd0;
        v_col  = r_col;
        v_seq  = '0;
        v_m    = 2'd0;
        v_lim  = (i_line_length < b64w_pkg::LINE_LEN_MIN) ? b64w_pkg::LINE_LEN_MIN
                                                          : i_line_length;
        n_bits = 4'd0;
        n_cnt  = 3'd0;

        // A carriage return held back from the previous flush goes first.
        if (r_pending) begin
            v_buf[0] = b64w_pkg::CHAR_CR;
            v_n      = 4'd1;
        end

        if (i_item.func == b64w_pkg::FUNC_DATA) begin
            case (v_cnt)
                3'd2: begin
                    v_seq[0] = b64w_pkg::sextet_char(v_acc[9:4]);
                    v_m      = 2'd1;
                    n_bits   = v_acc[3:0];
                    n_cnt    = 3'd4;
                end
                3'd4: begin
                    v_seq[0] = b64w_pkg::sextet_char(v_acc[11:6]);
                    v_seq[1] = b64w_pkg::sextet_char(v_acc[5:0]);
                    v_m      = 2'd2;
                end
                default: begin
                    v_seq[0] = b64w_pkg::sextet_char(v_acc[7:2]);
                    v_m      = 2'd1;
                    n_bits   = {2'b00, v_acc[1:0]};
                    n_cnt    = 3'd2;
                end
            endcase
        end else begin
            case (v_cnt)
                3'd2: begin
                    v_seq[0] = b64w_pkg::sextet_char({v_bits[1:0], 4'b0000});
                    v_seq[1] = b64w_pkg::CHAR_PAD;
                    v_seq[2] = b64w_pkg::CHAR_PAD;
                    v_m      = 2'd3;
                end
                3'd4: begin
                    v_seq[0] = b64w_pkg::sextet_char({v_bits, 2'b00});
                    v_seq[1] = b64w_pkg::CHAR_PAD;
                    v_m      = 2'd2;
                end
                default: begin
                    v_m = 2'd0;
                end
            endcase
        end

        // Each counted character advances the column and may end the line.
        for (int k = 0; k < 3; k++) begin
            if (2'(k) < v_m) begin
                if (v_n < 4'd8) begin
                    v_buf[v_n[2:0]] = v_seq[k];
                    v_n = v_n + 4'd1;
                end
                v_col = v_col + 8'd1;
                if (v_col >= v_lim || v_col == 8'd0) begin
                    if (v_n < 4'd8) begin
                        v_buf[v_n[2:0]] = b64w_pkg::CHAR_CR;
                        v_n = v_n + 4'd1;
                    end
                    v_col = 8'd0;
                end
            end
        end

        if (i_item.func == b64w_pkg::FUNC_FLUSH && v_col != 8'd0) begin
            if (v_n < 4'd8) begin
                v_buf[v_n[2:0]] = b64w_pkg::CHAR_CR;
                v_n = v_n + 4'd1;
            end
            v_col = 8'd0;
        end

        n_col     = v_col;
        n_pending = (v_n > 4'd4);
        o_list.chars = v_buf[3:0];
        o_list.count = (v_n > 4'd4) ? 3'd4 : v_n[2:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bits    <= 4'd0;
            r_cnt     <= 3'd0;
            r_col     <= 8'd0;
            r_pending <= 1'b0;
        end else if (i_fire) begin
            r_bits    <= n_bits;
            r_cnt     <= n_cnt;
            r_col     <= n_col;
            r_pending <= n_pending;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/b64w_outq.sv =====
// ============================================================================
// b64w_outq
// Result register holding one item's characters and handing them out one per
// transaction.
// ============================================================================
`default_nettype none

module b64w_outq (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_load,
    input  wire b64w_pkg::t_char_list  i_list,
    output logic                       o_out_valid,
    input  wire logic                  i_out_stall,
    output b64w_pkg::t_out_item        o_out_data,
    output b64w_pkg::t_queue_status    o_status
);

    logic [b64w_pkg::MAX_RESULTS-1:0][7:0] r_chars;
    logic [2:0]                            r_cnt;
    logic [1:0]                            r_ptr;
    logic                                  r_busy;

    logic is_last;
    logic take;

    assign is_last = ({1'b0, r_ptr} == (r_cnt - 3'd1));
    assign take    = r_busy && !i_out_stall;

    assign o_out_valid         = r_busy;
    assign o_out_data.out_char = r_chars[r_ptr];
    assign o_out_data.run_last = is_last;
    assign o_status.busy       = r_busy;
    assign o_status.last_go    = take && is_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_ptr  <= 2'd0;
            r_cnt  <= 3'd0;
        end else if (i_load && i_list.count != 3'd0) begin
            r_busy  <= 1'b1;
            r_ptr   <= 2'd0;
            r_cnt   <= i_list.count;
            r_chars <= i_list.chars;
        end else if (take) begin
            if (is_last) begin
                r_busy <= 1'b0;
            end else begin
                r_ptr <= r_ptr + 2'd1;
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/base64_line_wrap_encoder.sv =====
// ============================================================================
// base64_line_wrap_encoder
// Base64 encoder with carriage-return line wrapping and end-of-message flush.
// ============================================================================
// The first character of an item is offered after the item passes the input
// register and is loaded into the result register, or later while earlier
// characters wait. Throughput: one item per cycle while items give at most one
// character and the output does not stall; otherwise an item holds the result
// register until its last character (up to four) is taken, which limits intake.
// Synchronous active-low reset clears the encoder state, line length back to 75.
`default_nettype none

module base64_line_wrap_encoder (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    // Input channel
    input  wire logic                 i_in_valid,
    output logic                      o_in_stall,
    input  wire b64w_pkg::t_in_item   i_in_data,
    // Output channel
    output logic                      o_out_valid,
    input  wire logic                 i_out_stall,
    output b64w_pkg::t_out_item       o_out_data,
    // Configuration: line length
    input  wire logic                 i_cfg_we,
    input  wire logic [7:0]           i_cfg_wdata
);

    // Line length register. Values below four are treated as four by the
    // encoding logic, so any written value is stored as it stands.
    logic [7:0] r_line_length;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_length <= b64w_pkg::LINE_LEN_RESET;
        end else if (i_cfg_we) begin
            r_line_length <= i_cfg_wdata;
        end
    end

    // Input register. An accepted item waits here until the result register
    // is free, or is being freed in the same cycle by its final transaction.
    logic                  r_in_valid;
    b64w_pkg::t_in_item    r_in;
    logic                  in_accept;
    logic                  fire;
    b64w_pkg::t_queue_status q_status;
    b64w_pkg::t_char_list  list;

    assign fire       = r_in_valid && (!q_status.busy || q_status.last_go);
    assign o_in_stall = r_in_valid && !fire;
    assign in_accept  = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_accept) begin
            r_in_valid <= 1'b1;
        end else if (fire) begin
            r_in_valid <= 1'b0;
        end
    end

    // The payload register needs no reset; it is only used when valid.
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in <= i_in_data;
        end
    end

    // When the item fires, the core works out all of its characters in one
    // pass and updates the leftover bits, the column and the deferred break.
    b64w_core u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_fire        (fire),
        .i_item        (r_in),
        .i_line_length (r_line_length),
        .o_list        (list)
    );

    // The character list is held in the result register and handed out one
    // character per output transaction, the last one flagged by run_last.
    // An item that gives no character never occupies it.
    b64w_outq u_outq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (fire),
        .i_list      (list),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .o_status    (q_status)
    );

endmodule

`default_nettype wire
